>>> hdl/dsp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command codes and controller/datapath interface types
// for the shortest-path core. Depends on nothing.
package dsp_pkg;

   localparam int MAX_NODES_DEF  = 64;
   localparam int MAX_EDGES_DEF  = 256;
   localparam int DIST_WIDTH_DEF = 32;

   localparam int NODE_W    = 6;
   localparam int MAX_NODES = 2 ** NODE_W;
   localparam int NCNT_W    = NODE_W + 1;
   localparam int COST_W    = 16;
   localparam int CMD_W     = 2;
   localparam int STAT_W    = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic              clr_fill;
      logic              add_edge;
      logic              single;
      logic [STAT_W-1:0] single_status;
      logic              init_start;
      logic              init_step;
      logic              scan_start;
      logic              scan_run;
      logic              visit;
      logic              edge_start;
      logic              edge_issue;
      logic              dist_issue;
      logic              relax;
      logic              out_start;
      logic              out_issue;
      logic              out_load;
   } dsp_cmd_type;

   typedef struct packed {
      logic src_ok;
      logic i_last;
      logic i_end;
      logic scan_done;
      logic found;
      logic edge_end;
      logic edge_match;
      logic rsp_busy;
   } dsp_stat_type;

endpackage

>>> hdl/dsp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/dsp_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the shortest-path core: sequences clear, add,
// initialisation, node scan, edge relaxation and result output. Uses dsp_pkg.
module dsp_ctrl import dsp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             csr_ready,
   input  dsp_stat_type     st,
   output dsp_cmd_type      cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_EDGE  = 4'd3;
   localparam logic [3:0] S_ECHK  = 4'd4;
   localparam logic [3:0] S_EUPD  = 4'd5;
   localparam logic [3:0] S_ORD   = 4'd6;
   localparam logic [3:0] S_OLD   = 4'd7;
   localparam logic [3:0] S_OWAIT = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       accept;

   assign req_stall = !((state_ff == S_IDLE) && !st.rsp_busy);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     cmd.clr_fill      = 1'b1;
                     cmd.single        = 1'b1;
                     cmd.single_status = ST_OK;
                  end
                  CMD_ADD: begin
                     cmd.add_edge = 1'b1;
                  end
                  CMD_SEARCH: begin
                     if (st.src_ok) begin
                        cmd.init_start = 1'b1;
                        state_in       = S_INIT;
                     end else begin
                        cmd.single        = 1'b1;
                        cmd.single_status = ST_RANGE;
                     end
                  end
                  default: begin
                     cmd.single        = 1'b1;
                     cmd.single_status = ST_RANGE;
                  end
               endcase
            end
         end
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (st.i_last) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (st.scan_done) begin
               if (st.found) begin
                  cmd.visit      = 1'b1;
                  cmd.edge_start = 1'b1;
                  state_in       = S_EDGE;
               end else begin
                  cmd.out_start = 1'b1;
                  state_in      = S_ORD;
               end
            end
         end
         S_EDGE: begin
            if (st.edge_end) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               cmd.edge_issue = 1'b1;
               state_in       = S_ECHK;
            end
         end
         S_ECHK: begin
            if (st.edge_match) begin
               cmd.dist_issue = 1'b1;
               state_in       = S_EUPD;
            end else begin
               state_in = S_EDGE;
            end
         end
         S_EUPD: begin
            cmd.relax = 1'b1;
            state_in  = S_EDGE;
         end
         S_ORD: begin
            cmd.out_issue = 1'b1;
            state_in      = S_OLD;
         end
         S_OLD: begin
            cmd.out_load = 1'b1;
            state_in     = S_OWAIT;
         end
         S_OWAIT: begin
            if (!st.rsp_busy) begin
               state_in = st.i_end ? S_IDLE : S_ORD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/dsp_datapath.sv
`timescale 1ns / 1ps
// Datapath of the shortest-path core: node count register, edge table and
// distance memories, visited flags, scan and relaxation logic and the result
// register. Uses dsp_pkg and dsp_ram.
module dsp_datapath import dsp_pkg::*; #(
   parameter int MAX_EDGES  = MAX_EDGES_DEF,
   parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [NCNT_W-1:0]     csr_data,
   input  logic [NODE_W-1:0]     req_edge_source,
   input  logic [NODE_W-1:0]     req_edge_dest,
   input  logic [COST_W-1:0]     req_edge_cost,
   input  logic [NODE_W-1:0]     req_source_node,
   input  dsp_cmd_type           cmd,
   output dsp_stat_type          st,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [NODE_W-1:0]     rsp_node_index,
   output logic [DIST_WIDTH-1:0] rsp_distance,
   output logic                  rsp_reached,
   output logic                  rsp_all_reached,
   output logic [STAT_W-1:0]     rsp_status,
   output logic                  rsp_last
);

   localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EC_W  = $clog2(MAX_EDGES + 1);
   localparam int ENT_W = 2 * NODE_W + COST_W;
   localparam logic [DIST_WIDTH-1:0] DIST_INF = {DIST_WIDTH{1'b1}};

   logic [NCNT_W-1:0]     node_count_ff, node_count_in;
   logic [EC_W-1:0]       edge_fill_ff, edge_fill_in;
   logic [NODE_W-1:0]     src_ff, src_in;
   logic [NCNT_W-1:0]     idx_ff, idx_in;
   logic [NODE_W-1:0]     idx_rd_ff, idx_rd_in;
   logic                  scan_pend_ff, scan_pend_in;
   logic [DIST_WIDTH-1:0] best_ff, best_in;
   logic [NODE_W-1:0]     pick_ff, pick_in;
   logic                  found_ff, found_in;
   logic [MAX_NODES-1:0]  visited_ff, visited_in;
   logic [EC_W-1:0]       eidx_ff, eidx_in;
   logic                  all_ff, all_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [DIST_WIDTH-1:0] rsp_dist_ff, rsp_dist_in;
   logic                  rsp_reached_ff, rsp_reached_in;
   logic                  rsp_all_ff, rsp_all_in;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [ENT_W-1:0]      edge_rd;
   logic [NODE_W-1:0]     e_src, e_dst;
   logic [COST_W-1:0]     e_cost;
   logic                  edge_wr;
   logic [STAT_W-1:0]     add_status;
   logic [DIST_WIDTH-1:0] dist_rd;
   logic [DIST_WIDTH:0]   sum;
   logic [DIST_WIDTH-1:0] alt;
   logic                  dist_wr;
   logic [NODE_W-1:0]     dist_wr_addr;
   logic [DIST_WIDTH-1:0] dist_wr_data;
   logic                  dist_rd_en;
   logic [NODE_W-1:0]     dist_rd_addr;
   logic                  scan_issue;
   logic                  reached;

   assign e_src  = edge_rd[ENT_W-1 -: NODE_W];
   assign e_dst  = edge_rd[COST_W +: NODE_W];
   assign e_cost = edge_rd[COST_W-1:0];

   always_comb begin
      if (({1'b0, req_edge_source} >= node_count_ff) ||
          ({1'b0, req_edge_dest} >= node_count_ff)) begin
         add_status = ST_RANGE;
      end else if (edge_fill_ff == EC_W'(MAX_EDGES)) begin
         add_status = ST_FULL;
      end else begin
         add_status = ST_OK;
      end
   end

   assign edge_wr = cmd.add_edge && (add_status == ST_OK);

   dsp_ram #(.WIDTH(ENT_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr),
      .wr_addr (edge_fill_ff[EA_W-1:0]),
      .wr_data ({req_edge_source, req_edge_dest, req_edge_cost}),
      .rd_en   (cmd.edge_issue),
      .rd_addr (eidx_ff[EA_W-1:0]),
      .rd_data (edge_rd)
   );

   assign sum = {1'b0, best_ff} + (DIST_WIDTH + 1)'(e_cost);
   assign alt = (sum >= {1'b0, DIST_INF}) ? (DIST_INF - 1'b1) : sum[DIST_WIDTH-1:0];

   assign scan_issue   = cmd.scan_run && (idx_ff < node_count_ff);
   assign dist_wr      = cmd.init_step || (cmd.relax && (alt < dist_rd));
   assign dist_wr_addr = cmd.init_step ? idx_ff[NODE_W-1:0] : e_dst;
   assign dist_wr_data = cmd.init_step ?
                         ((idx_ff[NODE_W-1:0] == src_ff) ? '0 : DIST_INF) : alt;
   assign dist_rd_en   = scan_issue || cmd.dist_issue || cmd.out_issue;
   assign dist_rd_addr = cmd.dist_issue ? e_dst : idx_ff[NODE_W-1:0];

   dsp_ram #(.WIDTH(DIST_WIDTH), .DEPTH(MAX_NODES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_wr),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_en   (dist_rd_en),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_rd)
   );

   assign reached = (dist_rd != DIST_INF);

   always_comb begin
      node_count_in  = node_count_ff;
      edge_fill_in   = edge_fill_ff;
      src_in         = src_ff;
      idx_in         = idx_ff;
      idx_rd_in      = idx_rd_ff;
      scan_pend_in   = scan_pend_ff;
      best_in        = best_ff;
      pick_in        = pick_ff;
      found_in       = found_ff;
      visited_in     = visited_ff;
      eidx_in        = eidx_ff;
      all_in         = all_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_index_in   = rsp_index_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_reached_in = rsp_reached_ff;
      rsp_all_in     = rsp_all_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         if (csr_data == '0) begin
            node_count_in = NCNT_W'(1);
         end else if (csr_data > NCNT_W'(MAX_NODES)) begin
            node_count_in = NCNT_W'(MAX_NODES);
         end else begin
            node_count_in = csr_data;
         end
      end

      if (cmd.clr_fill) begin
         edge_fill_in = '0;
      end
      if (edge_wr) begin
         edge_fill_in = edge_fill_ff + EC_W'(1);
      end

      if (cmd.single || cmd.add_edge) begin
         rsp_valid_in   = 1'b1;
         rsp_index_in   = '0;
         rsp_dist_in    = '0;
         rsp_reached_in = 1'b0;
         rsp_all_in     = 1'b0;
         rsp_status_in  = cmd.add_edge ? add_status : cmd.single_status;
         rsp_last_in    = 1'b1;
      end

      if (cmd.init_start) begin
         src_in     = req_source_node;
         idx_in     = '0;
         visited_in = '0;
      end
      if (cmd.init_step) begin
         idx_in = idx_ff + NCNT_W'(1);
      end

      if (cmd.scan_start) begin
         idx_in       = '0;
         best_in      = DIST_INF;
         found_in     = 1'b0;
         scan_pend_in = 1'b0;
      end
      if (cmd.scan_run) begin
         scan_pend_in = scan_issue;
         if (scan_issue) begin
            idx_rd_in = idx_ff[NODE_W-1:0];
            idx_in    = idx_ff + NCNT_W'(1);
         end
         if (scan_pend_ff && !visited_ff[idx_rd_ff] && (dist_rd < best_ff)) begin
            best_in  = dist_rd;
            pick_in  = idx_rd_ff;
            found_in = 1'b1;
         end
      end
      if (cmd.visit) begin
         visited_in[pick_ff] = 1'b1;
      end

      if (cmd.edge_start) begin
         eidx_in = '0;
      end
      if (cmd.edge_issue) begin
         eidx_in = eidx_ff + EC_W'(1);
      end

      if (cmd.out_start) begin
         idx_in = '0;
         all_in = 1'b1;
      end
      if (cmd.out_issue) begin
         idx_rd_in = idx_ff[NODE_W-1:0];
         idx_in    = idx_ff + NCNT_W'(1);
      end
      if (cmd.out_load) begin
         all_in         = all_ff && reached;
         rsp_valid_in   = 1'b1;
         rsp_index_in   = idx_rd_ff;
         rsp_dist_in    = dist_rd;
         rsp_reached_in = reached;
         rsp_all_in     = st.i_end && all_ff && reached;
         rsp_status_in  = ST_OK;
         rsp_last_in    = st.i_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NCNT_W'(MAX_NODES);
         edge_fill_ff  <= '0;
         scan_pend_ff  <= 1'b0;
         found_ff      <= 1'b0;
         visited_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         edge_fill_ff  <= edge_fill_in;
         scan_pend_ff  <= scan_pend_in;
         found_ff      <= found_in;
         visited_ff    <= visited_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff         <= src_in;
      idx_ff         <= idx_in;
      idx_rd_ff      <= idx_rd_in;
      best_ff        <= best_in;
      pick_ff        <= pick_in;
      eidx_ff        <= eidx_in;
      all_ff         <= all_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_reached_ff <= rsp_reached_in;
      rsp_all_ff     <= rsp_all_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign st.src_ok     = ({1'b0, req_source_node} < node_count_ff);
   assign st.i_last     = (idx_ff == node_count_ff - NCNT_W'(1));
   assign st.i_end      = (idx_ff == node_count_ff);
   assign st.scan_done  = (idx_ff == node_count_ff) && !scan_pend_ff;
   assign st.found      = found_ff;
   assign st.edge_end   = (eidx_ff == edge_fill_ff);
   assign st.edge_match = (e_src == pick_ff) && ({1'b0, e_dst} < node_count_ff);
   assign st.rsp_busy   = rsp_valid_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_index  = rsp_index_ff;
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_reached     = rsp_reached_ff;
   assign rsp_all_reached = rsp_all_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (node_count_ff != '0) && (node_count_ff <= NCNT_W'(MAX_NODES)))
      else $error("node count out of range");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      edge_fill_ff <= EC_W'(MAX_EDGES))
      else $error("edge fill beyond table size");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load || cmd.single || cmd.add_edge) |-> !rsp_valid_ff)
      else $error("result beat overwritten before it was taken");

endmodule

>>> hdl/dijkstra_shortest_paths_core.sv
`timescale 1ns / 1ps
// Top level of the shortest-path core: controller plus datapath.
// Uses dsp_pkg, dsp_ctrl, dsp_datapath and dsp_ram.
// The core takes one request beat at a time. Clear and add give a single
// result beat in the cycle after acceptance. A search with N nodes in use
// first initialises all N distances, then for every reached node scans the
// distance memory for the nearest unvisited node and checks every stored
// edge, relaxing those that leave that node, through the single read port
// of each memory, and ends with one result beat per node. Requests are
// stalled until the last result beat of the previous request has been
// taken, and the node count is written only while no search is running.
module dijkstra_shortest_paths_core import dsp_pkg::*; #(
   parameter int MAX_EDGES  = MAX_EDGES_DEF,
   parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [NCNT_W-1:0]     csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [NODE_W-1:0]     req_edge_source,
   input  logic [NODE_W-1:0]     req_edge_dest,
   input  logic [COST_W-1:0]     req_edge_cost,
   input  logic [NODE_W-1:0]     req_source_node,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [NODE_W-1:0]     rsp_node_index,
   output logic [DIST_WIDTH-1:0] rsp_distance,
   output logic                  rsp_reached,
   output logic                  rsp_all_reached,
   output logic [STAT_W-1:0]     rsp_status,
   output logic                  rsp_last
);

   dsp_cmd_type  cmd;
   dsp_stat_type st;

   dsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .csr_ready (csr_ready),
      .st        (st),
      .cmd       (cmd)
   );

   dsp_datapath #(.MAX_EDGES(MAX_EDGES), .DIST_WIDTH(DIST_WIDTH)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .req_edge_source (req_edge_source),
      .req_edge_dest   (req_edge_dest),
      .req_edge_cost   (req_edge_cost),
      .req_source_node (req_source_node),
      .cmd             (cmd),
      .st              (st),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_node_index  (rsp_node_index),
      .rsp_distance    (rsp_distance),
      .rsp_reached     (rsp_reached),
      .rsp_all_reached (rsp_all_reached),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

>>> verif/tb_dijkstra_shortest_paths_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the shortest-path core: it drives clear, add and
// search beats, predicts every result beat in its own model and compares them.
// Depends on dsp_pkg and dijkstra_shortest_paths_core.
module tb_dijkstra_shortest_paths_core;
   import dsp_pkg::*;

   localparam int NEDGES = 256;
   localparam logic [31:0] INF = 32'hFFFF_FFFF;
   localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;
   localparam longint LIMIT = 3_000_000;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [NODE_W-1:0] src;
      logic [NODE_W-1:0] dst;
      logic [COST_W-1:0] cost;
      logic [NODE_W-1:0] start;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] idx;
      logic [31:0]       distance;
      logic              reached;
      logic              all;
      logic [STAT_W-1:0] status;
      logic              last;
   } rsp_type;

   logic clock = 1'b0, reset = 1'b1;
   logic csr_valid = 1'b0, csr_ready;
   logic [NCNT_W-1:0] csr_data = '0;
   logic req_valid = 1'b0, req_stall;
   logic [CMD_W-1:0] req_cmd = '0;
   logic [NODE_W-1:0] req_edge_source = '0, req_edge_dest = '0, req_source_node = '0;
   logic [COST_W-1:0] req_edge_cost = '0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic [NODE_W-1:0] rsp_node_index;
   logic [31:0] rsp_distance;
   logic rsp_reached, rsp_all_reached, rsp_last;
   logic [STAT_W-1:0] rsp_status;

   dijkstra_shortest_paths_core uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   int unsigned nodes_in_use = 64;
   int unsigned edges_held = 0;
   logic [NODE_W-1:0] edge_src [NEDGES];
   logic [NODE_W-1:0] edge_dst [NEDGES];
   logic [COST_W-1:0] edge_cost [NEDGES];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int errors = 0;
   int send_idle_pct = 0, recv_idle_pct = 0;
   bit hold_rsp = 1'b0;
   longint cycles = 0;

   function automatic rsp_type one_beat(logic [STAT_W-1:0] st);
      rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic expect_beat(input rsp_type r);
      expected_rsps = {expected_rsps, r};
   endtask

   task automatic predict_paths(input req_type q);
      logic [31:0] node_dist [64];
      bit visited [64];
      logic [31:0] best, alt;
      int unsigned pick, i, e;
      bit found, all;
      rsp_type r;
      if (q.cmd == CMD_CLEAR) begin
         edges_held = 0;
         expect_beat(one_beat(ST_OK));
      end else if (q.cmd == CMD_ADD) begin
         if (q.src >= nodes_in_use || q.dst >= nodes_in_use)
            expect_beat(one_beat(ST_RANGE));
         else if (edges_held >= NEDGES)
            expect_beat(one_beat(ST_FULL));
         else begin
            edge_src[edges_held] = q.src;
            edge_dst[edges_held] = q.dst;
            edge_cost[edges_held] = q.cost;
            edges_held++;
            expect_beat(one_beat(ST_OK));
         end
      end else if (q.cmd != CMD_SEARCH || q.start >= nodes_in_use) begin
         expect_beat(one_beat(ST_RANGE));
      end else begin
         for (i = 0; i < 64; i++) begin
            node_dist[i] = INF;
            visited[i] = 0;
         end
         node_dist[q.start] = 0;
         forever begin
            best = INF;
            pick = 0;
            found = 0;
            for (i = 0; i < nodes_in_use; i++)
               if (!visited[i] && node_dist[i] < best) begin
                  best = node_dist[i];
                  pick = i;
                  found = 1;
               end
            if (!found) break;
            visited[pick] = 1;
            for (e = 0; e < edges_held; e++) begin
               if (edge_src[e] != pick || edge_dst[e] >= nodes_in_use) continue;
               if ({16'd0, edge_cost[e]} > (INF - 1) - best) alt = INF - 1;
               else alt = best + {16'd0, edge_cost[e]};
               if (alt < node_dist[edge_dst[e]]) node_dist[edge_dst[e]] = alt;
            end
         end
         all = 1;
         for (i = 0; i < nodes_in_use; i++)
            if (node_dist[i] == INF) all = 0;
         for (i = 0; i < nodes_in_use; i++) begin
            r = '0;
            r.idx = NODE_W'(i);
            r.distance = node_dist[i];
            r.reached = node_dist[i] != INF;
            r.last = i + 1 == nodes_in_use;
            r.all = r.last && all;
            expect_beat(r);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
   endtask

   // Driver: the payload is held while stalled.
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (req_valid) predict_paths({req_cmd, req_edge_source, req_edge_dest,
                                          req_edge_cost, req_source_node});
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_type q;
               q = pending_reqs.pop_front();
               req_valid <= 1'b1;
               {req_cmd, req_edge_source, req_edge_dest, req_edge_cost,
                req_source_node} <= q;
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off early in the first random phase.
   initial begin
      wait (send_idle_pct == 15);
      repeat (5) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Monitor and receiver back-pressure.
   always @(posedge clock) begin
      rsp_type r;
      cycles++;
      if (cycles > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0)
               report_mismatch("unexpected beat", 32'(rsp_node_index), 32'd0);
            else begin
               r = expected_rsps.pop_front();
               if (rsp_node_index !== r.idx)
                  report_mismatch("node_index", 32'(rsp_node_index), 32'(r.idx));
               if (rsp_distance !== r.distance)
                  report_mismatch("distance", rsp_distance, r.distance);
               if (rsp_reached !== r.reached)
                  report_mismatch("reached", 32'(rsp_reached), 32'(r.reached));
               if (rsp_all_reached !== r.all)
                  report_mismatch("all_reached", 32'(rsp_all_reached), 32'(r.all));
               if (rsp_status !== r.status)
                  report_mismatch("status", 32'(rsp_status), 32'(r.status));
               if (rsp_last !== r.last)
                  report_mismatch("last", 32'(rsp_last), 32'(r.last));
            end
         end
         if (hold_rsp)
            rsp_stall <= 1'b1;
         else
            rsp_stall <= $urandom_range(99) < recv_idle_pct;
      end
   end

   task automatic push_req(input logic [CMD_W-1:0] c, input int s, input int d,
                           input int w, input int st);
      req_type q;
      q.cmd = c;
      q.src = NODE_W'(s);
      q.dst = NODE_W'(d);
      q.cost = COST_W'(w);
      q.start = NODE_W'(st);
      pending_reqs = {pending_reqs, q};
   endtask

   task automatic drain;
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_nodes(input int n);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= NCNT_W'(n);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (n == 0) nodes_in_use = 1;
      else if (n > 64) nodes_in_use = 64;
      else nodes_in_use = n;
   endtask

   // A well-formed graph of random edges followed by searches, with some noise.
   task automatic random_graph(input int n, input int nedges, input int nsearch);
      push_req(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
      repeat (nedges)
         push_req(CMD_ADD, $urandom_range(n - 1), $urandom_range(n - 1),
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(40),
                  $urandom);
      repeat (nsearch) begin
         if ($urandom_range(9) == 0) push_req(CMD_BAD, $urandom, $urandom, $urandom, $urandom);
         if ($urandom_range(9) == 0) push_req(CMD_ADD, $urandom, $urandom, $urandom, $urandom);
         push_req(CMD_SEARCH, $urandom, $urandom, $urandom,
                  ($urandom_range(7) == 0) ? $urandom : $urandom_range(n - 1));
      end
   endtask

   initial begin
      int phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, saturation, ties, stale edges, bad codes.
      write_nodes(4);
      push_req(CMD_ADD, 0, 1, 16'hFFFF, 0);
      push_req(CMD_ADD, 0, 2, 16'hFFFF, 0);
      push_req(CMD_ADD, 1, 3, 1, 0);
      push_req(CMD_ADD, 2, 3, 1, 0);
      push_req(CMD_ADD, 63, 0, 5, 0);
      push_req(CMD_ADD, 0, 63, 5, 0);
      push_req(CMD_SEARCH, 0, 0, 0, 0);
      push_req(CMD_SEARCH, 0, 0, 0, 3);
      push_req(CMD_SEARCH, 0, 0, 0, 63);
      push_req(CMD_BAD, 63, 63, 16'hFFFF, 63);
      drain();
      write_nodes(2);
      push_req(CMD_SEARCH, 63, 63, 16'hFFFF, 1);
      drain();
      write_nodes(0);
      push_req(CMD_SEARCH, 0, 0, 0, 0);
      push_req(CMD_ADD, 0, 0, 7, 0);
      push_req(CMD_SEARCH, 0, 0, 0, 0);
      drain();
      write_nodes(127);
      push_req(CMD_CLEAR, 0, 0, 0, 0);
      push_req(CMD_ADD, 0, 63, 16'hFFFF, 0);
      push_req(CMD_ADD, 63, 62, 16'hFFFF, 0);
      push_req(CMD_SEARCH, 0, 0, 0, 0);
      drain();

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 61 : 0;
         recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 15 : 0;
         write_nodes($urandom_range(2, 12));
         random_graph(nodes_in_use, $urandom_range(4, 20), 8);
         drain();
      end
      write_nodes(64);
      random_graph(64, 30, 3);
      drain();
      write_nodes(1);
      random_graph(1, 3, 3);
      drain();

      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

>>> sim.f
hdl/dsp_pkg.sv
hdl/dsp_ram.sv
hdl/dsp_ctrl.sv
hdl/dsp_datapath.sv
hdl/dijkstra_shortest_paths_core.sv
verif/tb_dijkstra_shortest_paths_core.sv
